// ===== design/xor_trie_max_query_defines.svh =====
// Assertion helpers for the trie query block.
`ifndef XOR_TRIE_MAX_QUERY_DEFINES_SVH
`define XOR_TRIE_MAX_QUERY_DEFINES_SVH

// Antecedent true implies consequent in the same cycle.
`define XTQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must never hold.
`define XTQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== design/xtq_pkg.sv =====
`default_nettype none

package xtq_pkg;

   // action field codes
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   // trie walk sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INSERT,
      ST_QUERY,
      ST_DONE
   } eng_state_type;

   // status bits carried with each result
   typedef struct packed {
      logic found;
      logic store_full;
   } res_flags_type;

endpackage

`default_nettype wire

// ===== design/xtq_fifo.sv =====
`default_nettype none

module xtq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/xtq_front.sv =====
`default_nettype none

module xtq_front #(
   parameter int KEY_BITS = 30,
   parameter int IDX_BITS = 14,
   parameter int LIM_BITS = 15
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic                req_action,
   input  wire logic [KEY_BITS-1:0] req_key_value,
   input  wire logic [IDX_BITS-1:0] req_entry_index,
   input  wire logic [LIM_BITS-1:0] req_index_limit,
   input  wire logic                cmd_pop,
   output logic                     cmd_empty,
   output logic [KEY_BITS+LIM_BITS:0] cmd_data
);

   localparam int CMD_BITS = 1 + KEY_BITS + LIM_BITS;

   logic [LIM_BITS-1:0] tag;
   logic [CMD_BITS-1:0] cmd_word;

   // an insert carries its stamp, a query its limit, in one tag field
   always_comb begin
      unique case (req_action)
         xtq_pkg::ACTION_INSERT: tag = LIM_BITS'(req_entry_index);
         xtq_pkg::ACTION_QUERY:  tag = req_index_limit;
         default:                tag = req_index_limit;
      endcase
      cmd_word = {req_action, req_key_value, tag};
   end

   // command queue towards the trie engine
   xtq_fifo #(
      .WIDTH (CMD_BITS),
      .DEPTH (2)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_data (cmd_word),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_data)
   );

endmodule

`default_nettype wire

// ===== design/xtq_engine.sv =====
`default_nettype none

module xtq_engine #(
   parameter int KEY_BITS   = 30,
   parameter int NODE_COUNT = 32768,
   parameter int IDX_BITS   = 14,
   parameter int LIM_BITS   = 15
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       cmd_empty,
   input  wire logic [KEY_BITS+LIM_BITS:0] cmd_data,
   output logic                            cmd_pop,
   input  wire logic                       res_full,
   output logic                            res_push,
   output logic [KEY_BITS-1:0]             res_best_xor,
   output xtq_pkg::res_flags_type          res_flags
);

   localparam int NODE_BITS = $clog2(NODE_COUNT);
   localparam int CNT_BITS  = $clog2(NODE_COUNT + 1);
   localparam int LVL_BITS  = $clog2(KEY_BITS + 1);
   localparam int HALF_BITS = NODE_BITS + IDX_BITS;
   localparam int WORD_BITS = 2 * HALF_BITS;
   localparam int SUM_BITS  = CNT_BITS + 1;

   // node word: {child1 link, child1 stamp, child0 link, child0 stamp}
   logic [WORD_BITS-1:0] node_mem [NODE_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WORD_BITS-1:0] wr_data;
   logic [NODE_BITS-1:0] rd_addr, wr_addr;
   logic                 mem_we;

   xtq_pkg::eng_state_type state_ff, state_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [KEY_BITS-1:0]    key_orig_ff, key_orig_in;
   logic [LIM_BITS-1:0]    tag_ff, tag_in;
   logic [NODE_BITS-1:0]   node_ff, node_in;
   logic [LVL_BITS-1:0]    rem_ff, rem_in;
   logic [KEY_BITS-1:0]    acc_ff, acc_in;
   logic                   fresh_ff, fresh_in;
   logic [CNT_BITS-1:0]    next_free_ff, next_free_in;
   xtq_pkg::res_flags_type flags_ff, flags_in;

   logic                 cmd_action;
   logic [KEY_BITS-1:0]  cmd_key;
   logic [LIM_BITS-1:0]  cmd_tag;
   logic                 cur_bit, root_blank, last_lvl;
   logic [WORD_BITS-1:0] word_eff;
   logic [HALF_BITS-1:0] half0, half1, path_half, other_half, new_half;
   logic [NODE_BITS-1:0] path_link, other_link, new_link;
   logic [IDX_BITS-1:0]  path_stamp, other_stamp;
   logic                 path_missing, path_ok, other_ok;
   logic                 overflow, near_full;

   assign cmd_action = cmd_data[KEY_BITS+LIM_BITS];
   assign cmd_key    = cmd_data[KEY_BITS+LIM_BITS-1:LIM_BITS];
   assign cmd_tag    = cmd_data[LIM_BITS-1:0];

   // current node word; fresh nodes and the untouched root read as empty
   always_comb begin
      cur_bit     = key_ff[KEY_BITS-1];
      last_lvl    = (rem_ff == LVL_BITS'(1));
      root_blank  = (node_ff == '0) && (next_free_ff == CNT_BITS'(1));
      word_eff    = (fresh_ff || root_blank) ? '0 : rd_data_ff;
      half0       = word_eff[HALF_BITS-1:0];
      half1       = word_eff[WORD_BITS-1:HALF_BITS];
      path_half   = cur_bit ? half1 : half0;
      other_half  = cur_bit ? half0 : half1;
      path_link   = path_half[HALF_BITS-1:IDX_BITS];
      path_stamp  = path_half[IDX_BITS-1:0];
      other_link  = other_half[HALF_BITS-1:IDX_BITS];
      other_stamp = other_half[IDX_BITS-1:0];
      path_missing = (path_link == '0);
      // query: other half is the opposite-bit child, path half the same-bit one
      other_ok = (other_link != '0) && (LIM_BITS'(other_stamp) < tag_ff);
      path_ok  = !path_missing && (LIM_BITS'(path_stamp) < tag_ff);
      // insert: allocate on a missing link, restamp the path child
      new_link = path_missing ? NODE_BITS'(next_free_ff) : path_link;
      new_half = {new_link, tag_ff[IDX_BITS-1:0]};
      wr_data  = cur_bit ? {new_half, other_half} : {other_half, new_half};
      // room checks
      overflow  = (SUM_BITS'(next_free_ff) + SUM_BITS'(rem_ff)) > SUM_BITS'(NODE_COUNT);
      near_full = (SUM_BITS'(next_free_ff) + SUM_BITS'(KEY_BITS)) > SUM_BITS'(NODE_COUNT);
   end

   // walk sequencer
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      key_orig_in  = key_orig_ff;
      tag_in       = tag_ff;
      node_in      = node_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      fresh_in     = fresh_ff;
      next_free_in = next_free_ff;
      flags_in     = flags_ff;
      cmd_pop      = 1'b0;
      res_push     = 1'b0;
      mem_we       = 1'b0;
      wr_addr      = node_ff;
      rd_addr      = node_ff;
      unique case (state_ff)
         xtq_pkg::ST_IDLE: begin
            rd_addr = '0;
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               key_orig_in = cmd_key;
               key_in      = cmd_key;
               tag_in      = cmd_tag;
               node_in     = '0;
               rem_in      = LVL_BITS'(KEY_BITS);
               acc_in      = '0;
               fresh_in    = 1'b0;
               if (cmd_action == xtq_pkg::ACTION_QUERY) begin
                  state_in = xtq_pkg::ST_QUERY;
               end else if (near_full) begin
                  state_in = xtq_pkg::ST_CHECK;
               end else begin
                  state_in = xtq_pkg::ST_INSERT;
               end
            end
         end
         xtq_pkg::ST_CHECK: begin
            // count nodes the insert would need before touching the store
            if (path_missing && overflow) begin
               flags_in = '{found: 1'b0, store_full: 1'b1};
               acc_in   = '0;
               state_in = xtq_pkg::ST_DONE;
            end else if (path_missing || last_lvl) begin
               rd_addr  = '0;
               key_in   = key_orig_ff;
               node_in  = '0;
               rem_in   = LVL_BITS'(KEY_BITS);
               state_in = xtq_pkg::ST_INSERT;
            end else begin
               rd_addr = path_link;
               node_in = path_link;
               key_in  = key_ff << 1;
               rem_in  = rem_ff - LVL_BITS'(1);
            end
         end
         xtq_pkg::ST_INSERT: begin
            mem_we  = 1'b1;
            rd_addr = new_link;
            node_in = new_link;
            key_in  = key_ff << 1;
            rem_in  = rem_ff - LVL_BITS'(1);
            if (path_missing) begin
               next_free_in = next_free_ff + 1'b1;
               fresh_in     = 1'b1;
            end
            if (last_lvl) begin
               flags_in = '{found: 1'b0, store_full: 1'b0};
               acc_in   = '0;
               state_in = xtq_pkg::ST_DONE;
            end
         end
         xtq_pkg::ST_QUERY: begin
            key_in = key_ff << 1;
            rem_in = rem_ff - LVL_BITS'(1);
            priority if (other_ok) begin
               rd_addr = other_link;
               node_in = other_link;
               acc_in  = KEY_BITS'({acc_ff, 1'b1});
            end else if (path_ok) begin
               rd_addr = path_link;
               node_in = path_link;
               acc_in  = KEY_BITS'({acc_ff, 1'b0});
            end else begin
               acc_in = '0;
            end
            if (!other_ok && !path_ok) begin
               flags_in = '{found: 1'b0, store_full: 1'b0};
               state_in = xtq_pkg::ST_DONE;
            end else if (last_lvl) begin
               flags_in = '{found: 1'b1, store_full: 1'b0};
               state_in = xtq_pkg::ST_DONE;
            end
         end
         xtq_pkg::ST_DONE: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = xtq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xtq_pkg::ST_IDLE;
         end
      endcase
   end

   assign res_best_xor = acc_ff;
   assign res_flags    = flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xtq_pkg::ST_IDLE;
         next_free_ff <= CNT_BITS'(1);
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
      end
   end

   // walk payload
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      key_orig_ff <= key_orig_in;
      tag_ff      <= tag_in;
      node_ff     <= node_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      fresh_ff    <= fresh_in;
      flags_ff    <= flags_in;
   end

   // node store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/xor_trie_max_query.sv =====
// Binary trie of KEY_BITS-bit values with a greedy maximum-xor query.
// Request side is a queue: a beat is taken when req_push is high and
// req_full is low. An insert (action 0) stores req_key_value and stamps
// every node on its path with req_entry_index; a query (action 1) returns
// the largest key xor stored value among values whose stamp is below
// req_index_limit, with rsp_found low and 0 when none qualifies.
// Result side is a queue: rsp_* shows the oldest result while rsp_empty is
// low; rsp_pop takes it. An insert that does not fit raises rsp_store_full.
// One result per request, in order. Each item walks the node store one key
// bit per cycle (one registered read per level) and holds the engine until
// its result is pushed; once fewer than KEY_BITS free nodes remain, an insert
// first walks a read-only counting pass. The engine takes no new request
// while an item is in flight, and the request and result queues each
// register their beats.
// A stalled result side fills the two-beat result queue, then the engine
// holds its finished item, then the two-beat request queue fills and
// req_full rises. Reset empties both queues and the trie; no clearing
// pass is needed, the block takes requests on the first cycle after reset.
`default_nettype none

`include "xor_trie_max_query_defines.svh"

module xor_trie_max_query #(
   parameter int KEY_BITS    = 30,
   parameter int NODE_COUNT  = 32768,
   parameter int INDEX_COUNT = 16384
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic                                   req_action,
   input  wire logic [KEY_BITS-1:0]                    req_key_value,
   input  wire logic [$clog2(INDEX_COUNT)-1:0]         req_entry_index,
   input  wire logic [$clog2(INDEX_COUNT+1)-1:0]       req_index_limit,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic [KEY_BITS-1:0]                         rsp_best_xor,
   output logic                                        rsp_found,
   output logic                                        rsp_store_full
);

   localparam int IDX_BITS = $clog2(INDEX_COUNT);
   localparam int LIM_BITS = $clog2(INDEX_COUNT + 1);
   localparam int CMD_BITS = 1 + KEY_BITS + LIM_BITS;
   localparam int RES_BITS = KEY_BITS + 2;

   logic                   cmd_pop, cmd_empty;
   logic [CMD_BITS-1:0]    cmd_data;
   logic                   res_push, res_full;
   logic [KEY_BITS-1:0]    res_best_xor;
   xtq_pkg::res_flags_type res_flags, rsp_flags;
   logic [RES_BITS-1:0]    rsp_word;

   // front: take and classify request beats
   xtq_front #(
      .KEY_BITS (KEY_BITS),
      .IDX_BITS (IDX_BITS),
      .LIM_BITS (LIM_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_action      (req_action),
      .req_key_value   (req_key_value),
      .req_entry_index (req_entry_index),
      .req_index_limit (req_index_limit),
      .cmd_pop         (cmd_pop),
      .cmd_empty       (cmd_empty),
      .cmd_data        (cmd_data)
   );

   // back: trie walks over the node store
   xtq_engine #(
      .KEY_BITS   (KEY_BITS),
      .NODE_COUNT (NODE_COUNT),
      .IDX_BITS   (IDX_BITS),
      .LIM_BITS   (LIM_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_empty),
      .cmd_data     (cmd_data),
      .cmd_pop      (cmd_pop),
      .res_full     (res_full),
      .res_push     (res_push),
      .res_best_xor (res_best_xor),
      .res_flags    (res_flags)
   );

   // result queue
   xtq_fifo #(
      .WIDTH (RES_BITS),
      .DEPTH (2)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .full      (res_full),
      .push_data ({res_best_xor, res_flags}),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_word)
   );

   assign rsp_best_xor   = rsp_word[RES_BITS-1:2];
   assign rsp_flags      = rsp_word[1:0];
   assign rsp_found      = rsp_flags.found;
   assign rsp_store_full = rsp_flags.store_full;

   // checks
   `XTQ_ASSERT_IMPLY(a_res_room, clock, reset, res_push, !res_full, "result beat into full queue")
   `XTQ_ASSERT_IMPLY(a_cmd_avail, clock, reset, cmd_pop, !cmd_empty, "command taken from empty queue")
   `XTQ_ASSERT_IMPLY(a_miss_zero, clock, reset, !rsp_empty && !rsp_found, rsp_best_xor == '0, "nonzero answer without a match")
   `XTQ_ASSERT_NEVER(a_flag_excl, clock, reset, !rsp_empty && rsp_found && rsp_store_full, "found and store full together")

endmodule

`default_nettype wire
